// ===== rtl/core/gcb_pkg.sv =====
`timescale 1ns / 1ps

package gcb_pkg;

	localparam int LEN_W        = 17;
	localparam int MIN_W        = 16;
	localparam int HASH_W       = 64;
	localparam int LENGTH_LIMIT = 65536;
	localparam int TBL_DEPTH    = 256;
	localparam int TBL_AW       = 8;
	localparam int QDEPTH       = 4;
	localparam int QAW          = 2;
	localparam int QCW          = 3;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_EOS   = 2'd1;
	localparam logic [1:0] KIND_TABLE = 2'd2;

	localparam logic [1:0] CFG_MIN_SIZE = 2'd0;
	localparam logic [1:0] CFG_MAX_SIZE = 2'd1;
	localparam logic [1:0] CFG_CUT_MASK = 2'd2;

	typedef struct packed {
		logic [1:0]        kind;
		logic [7:0]        byte_value;
		logic [7:0]        table_index;
		logic [HASH_W-1:0] table_value;
	} gcb_in_t;

	typedef struct packed {
		logic [LEN_W-1:0] chunk_length;
		logic             is_final;
	} gcb_out_t;

	typedef struct packed {
		logic              is_eos;
		logic [HASH_W-1:0] gear;
	} gcb_qent_t;

	typedef struct packed {
		logic [MIN_W-1:0]  min_size;
		logic [LEN_W-1:0]  max_size;
		logic [HASH_W-1:0] cut_mask;
	} gcb_cfg_t;

endpackage

// ===== rtl/core/gear_chunk_boundary.sv =====
`timescale 1ns / 1ps
// Path: a result reaches the output register after the item that closes the chunk is accepted
//   and passes the gear table read, a queue slot and the hash/cut stage.
// Throughput: one item per cycle while the queue has room, set by the hash update and cut test.
// Reset (arst_n low, async): hash and chunk position clear, queue empties, config returns to
//   min_size 2048, max_size 65536, cut_mask 0xFFF8000000000000. Gear table is not cleared.
module gear_chunk_boundary import gcb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gcb_in_t           in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output gcb_out_t          out_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [HASH_W-1:0] cfg_data
);

	gcb_cfg_t       cfg_q;
	logic [QCW-1:0] q_count;
	logic           q_push;
	gcb_qent_t      q_data;
	logic           q_valid;
	gcb_qent_t      q_head;
	logic           q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_size <= MIN_W'(2048);
			cfg_q.max_size <= LEN_W'(65536);
			cfg_q.cut_mask <= 64'hFFF8_0000_0000_0000;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MIN_SIZE: cfg_q.min_size <= cfg_data[MIN_W-1:0];
				CFG_MAX_SIZE: cfg_q.max_size <= cfg_data[LEN_W-1:0];
				CFG_CUT_MASK: cfg_q.cut_mask <= cfg_data;
				default: ;
			endcase
		end
	end

	gcb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item (in_item),
		.q_count (q_count),
		.q_push  (q_push),
		.q_data  (q_data)
	);

	gcb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_data),
		.pop      (q_pop),
		.q_valid  (q_valid),
		.head     (q_head),
		.count    (q_count)
	);

	gcb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.head     (q_head),
		.pop      (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

endmodule

// ===== rtl/core/gcb_ram.sv =====
`timescale 1ns / 1ps

module gcb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== rtl/core/gcb_front.sv =====
`timescale 1ns / 1ps

module gcb_front import gcb_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  gcb_in_t        in_item,
	input  logic [QCW-1:0] q_count,
	output logic           q_push,
	output gcb_qent_t      q_data
);

	logic              accept;
	logic              is_table;
	logic              s1_valid_q;
	logic              s1_eos_q;
	logic [TBL_AW-1:0] ram_addr;
	logic [HASH_W-1:0] ram_rdata;

	// credit check: the item in flight in s1 already owns a queue slot
	assign in_ready = (q_count + QCW'(s1_valid_q)) < QCW'(QDEPTH);
	assign accept   = in_valid && in_ready;
	assign is_table = (in_item.kind == KIND_TABLE);
	assign ram_addr = is_table ? in_item.table_index : in_item.byte_value;

	gcb_ram #(
		.WIDTH(HASH_W),
		.DEPTH(TBL_DEPTH)
	) u_gear_tbl (
		.clk  (clk),
		.we   (accept && is_table),
		.re   (accept && (in_item.kind == KIND_DATA)),
		.addr (ram_addr),
		.wdata(in_item.table_value),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept && (in_item.kind inside {KIND_DATA, KIND_EOS});
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_eos_q <= (in_item.kind == KIND_EOS);
		end
	end

	assign q_push        = s1_valid_q;
	assign q_data.is_eos = s1_eos_q;
	assign q_data.gear   = ram_rdata;

endmodule

// ===== rtl/core/gcb_queue.sv =====
`timescale 1ns / 1ps

module gcb_queue import gcb_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gcb_qent_t      push_data,
	input  logic           pop,
	output logic           q_valid,
	output gcb_qent_t      head,
	output logic [QCW-1:0] count
);

	gcb_qent_t      ent_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCW'(push) - QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	assign q_valid = (count_q != '0);
	assign head    = ent_q[rd_ptr_q];
	assign count   = count_q;

endmodule

// ===== rtl/core/gcb_back.sv =====
`timescale 1ns / 1ps

module gcb_back import gcb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  gcb_cfg_t  cfg,
	input  logic      q_valid,
	input  gcb_qent_t head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output gcb_out_t  out_item
);

	logic [HASH_W-1:0] hash_q;
	logic [LEN_W-1:0]  pos_q;
	logic              out_valid_q;
	gcb_out_t          out_q;

	logic [LEN_W-1:0]  emax;
	logic              force_cut;
	logic [LEN_W-1:0]  pos_a;
	logic [HASH_W-1:0] hash_a;
	logic              hashing;
	logic [HASH_W-1:0] hash_sum;
	logic              hash_cut;
	logic              res_valid;
	logic              res_final;
	logic [HASH_W-1:0] hash_next;
	logic [LEN_W-1:0]  pos_next;

	always_comb begin
		if (cfg.max_size == '0) begin
			emax = LEN_W'(1);
		end else if (32'(cfg.max_size) > 32'(LENGTH_LIMIT)) begin
			emax = LEN_W'(LENGTH_LIMIT);
		end else begin
			emax = cfg.max_size;
		end
	end

	// forced cut first; it leaves the byte at position 0, so no hash cut follows
	assign force_cut = (pos_q >= emax);
	assign pos_a     = force_cut ? '0 : pos_q;
	assign hash_a    = force_cut ? '0 : hash_q;
	assign hashing   = (pos_a >= LEN_W'(cfg.min_size));
	assign hash_sum  = {hash_a[HASH_W-2:0], 1'b0} + head.gear;
	assign hash_cut  = hashing && ((hash_sum & cfg.cut_mask) == '0) && (pos_a != '0);

	always_comb begin
		if (head.is_eos) begin
			res_valid = (pos_q != '0);
			res_final = 1'b1;
			hash_next = '0;
			pos_next  = '0;
		end else begin
			res_valid = force_cut || hash_cut;
			res_final = 1'b0;
			if (hash_cut) begin
				hash_next = (cfg.min_size == '0) ? head.gear : '0;
				pos_next  = LEN_W'(1);
			end else begin
				hash_next = hashing ? hash_sum : hash_a;
				pos_next  = pos_a + 1'b1;
			end
		end
	end

	assign pop = q_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q      <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				hash_q <= hash_next;
				pos_q  <= pos_next;
			end
			if (pop && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			out_q.chunk_length <= pos_q;
			out_q.is_final     <= res_final;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== rtl/core/gcb_checker.sv =====
`timescale 1ns / 1ps

module gcb_checker import gcb_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     out_valid,
	input logic     out_ready,
	input gcb_out_t out_item,
	input logic     cfg_ready
);

	// chunks are never empty
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.chunk_length != '0))
		else $error("empty chunk reported");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
		else $error("stalled result changed");

	// nothing is pending right after reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid after reset");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind gear_chunk_boundary gcb_checker u_gcb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item (out_item),
	.cfg_ready(cfg_ready)
);

// ===== bench/gear_chunk_boundary_test.sv =====
`timescale 1ns / 1ps

module gear_chunk_boundary_test;
	import gcb_pkg::*;

	localparam logic [1:0]  KIND_SPARE   = 2'd3;
	localparam logic [1:0]  CFG_SPARE    = 2'd3;
	localparam logic [63:0] ALL_ONES     = '1;
	localparam int unsigned ITEM_TARGET  = 1600;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned STALL_LIMIT  = 4000;

	typedef enum logic [1:0] {PIN_FREE, PIN_NONE, PIN_ONE} pin_e;
	typedef enum logic {ROW_FEED, ROW_REG} row_op_e;

	typedef struct {
		row_op_e     op;
		gcb_in_t     item;
		logic [1:0]  sel;
		logic [63:0] val;
		pin_e        pin;
		gcb_out_t    want;
	} plan_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b1;
	logic              in_valid = 1'b0;
	logic              in_ready;
	gcb_in_t           in_item = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	gcb_out_t          out_item;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [HASH_W-1:0] cfg_data = '0;

	// sideband that travels with each item: expectation typed into the plan, if any
	pin_e     pin_mode = PIN_FREE;
	gcb_out_t pin_want = '0;

	// chunker mirror
	logic [HASH_W-1:0] gear_copy [TBL_DEPTH];
	logic [HASH_W-1:0] run_hash = '0;
	logic [LEN_W-1:0]  run_fill = '0;
	logic [MIN_W-1:0]  min_pos = 16'd2048;
	logic [LEN_W-1:0]  max_len = 17'd65536;
	logic [HASH_W-1:0] cut_bits = 64'hFFF8_0000_0000_0000;

	gcb_out_t    chunks_due [$];
	plan_row_t   plan [$];
	int unsigned mismatches = 0;
	int unsigned burst_left = 0;
	int unsigned quiet = 0;
	bit          hold_req = 1'b0;
	bit          hold_taken = 1'b0;

	gear_chunk_boundary dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		foreach (gear_copy[i]) gear_copy[i] = '0;
	end

	task automatic predict_cut(input gcb_in_t it, output bit made, output gcb_out_t res);
		int unsigned lim;
		made = 1'b0;
		res = '0;
		case (it.kind)
			KIND_TABLE: gear_copy[it.table_index] = it.table_value;
			KIND_EOS: begin
				if (run_fill != 0) begin
					made = 1'b1;
					res.chunk_length = run_fill;
					res.is_final = 1'b1;
				end
				run_fill = '0;
				run_hash = '0;
			end
			KIND_DATA: begin
				lim = (max_len == 0) ? 1 :
					((32'(max_len) > LENGTH_LIMIT) ? LENGTH_LIMIT : 32'(max_len));
				if (run_fill >= lim) begin
					made = 1'b1;
					res.chunk_length = run_fill;
					run_fill = '0;
					run_hash = '0;
				end
				if (run_fill >= min_pos) begin
					run_hash = (run_hash << 1) + gear_copy[it.byte_value];
					// never cut an empty chunk
					if ((run_hash & cut_bits) == '0 && run_fill != 0) begin
						made = 1'b1;
						res.chunk_length = run_fill;
						run_fill = '0;
						// closing byte opens the next chunk and is hashed there only when min_pos is zero
						run_hash = (min_pos == 0) ? gear_copy[it.byte_value] : '0;
					end
				end
				run_fill = run_fill + 1'b1;
			end
			default: ;
		endcase
	endtask

	function automatic void feed(input logic [1:0] k, input logic [7:0] bv, input logic [7:0] ti,
			input logic [63:0] tv, input pin_e pin, input int unsigned len,
			input int unsigned fin);
		plan_row_t row;
		row.op = ROW_FEED;
		row.item.kind = k;
		row.item.byte_value = bv;
		row.item.table_index = ti;
		row.item.table_value = tv;
		row.sel = '0;
		row.val = '0;
		row.pin = pin;
		row.want.chunk_length = LEN_W'(len);
		row.want.is_final = fin[0];
		plan = {plan, row};
	endfunction

	function automatic void setreg(input logic [1:0] sel, input logic [63:0] val);
		plan_row_t row;
		row.op = ROW_REG;
		row.item = '0;
		row.sel = sel;
		row.val = val;
		row.pin = PIN_FREE;
		row.want = '0;
		plan = {plan, row};
	endfunction

	function automatic gcb_in_t random_item();
		gcb_in_t it;
		int unsigned r;
		r = $urandom_range(0, 99);
		it.byte_value = 8'($urandom);
		it.table_index = 8'($urandom);
		it.table_value = {$urandom, $urandom};
		if (r < 86)
			it.kind = KIND_DATA;
		else if (r < 90)
			it.kind = KIND_EOS;
		else if (r < 97)
			it.kind = KIND_TABLE;
		else
			it.kind = KIND_SPARE;
		return it;
	endfunction

	task automatic send_item(input gcb_in_t it, input pin_e pin, input gcb_out_t want);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(100, 400);
			end else begin
				burst_left = $urandom_range(1, 40);
				gap = $urandom_range(0, 6);
			end
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		pin_mode <= pin;
		pin_want <= want;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
	endtask

	// leaves cfg_valid high; the caller lowers it after the last write of a batch
	task automatic write_reg(input logic [1:0] sel, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (sel)
			CFG_MIN_SIZE: min_pos = val[MIN_W-1:0];
			CFG_MAX_SIZE: max_len = val[LEN_W-1:0];
			CFG_CUT_MASK: cut_bits = val;
			default: ;
		endcase
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (chunks_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		plan_row_t        row;
		bit               streaming;
		int unsigned      fed, n, phase;
		logic [MIN_W-1:0] mn;
		logic [LEN_W-1:0] mx;
		logic [63:0]      mk;
		gcb_in_t          it;

		arst_n <= 1'b0;

		// reset config: bytes below min_size are only counted
		feed(KIND_TABLE, 8'h00, 8'h00, 64'd0, PIN_NONE, 0, 0);
		feed(KIND_TABLE, 8'h00, 8'hFF, ALL_ONES, PIN_NONE, 0, 0);
		feed(KIND_EOS, 8'h00, 8'h00, 64'd0, PIN_NONE, 0, 0);
		feed(KIND_DATA, 8'hFF, 8'h00, 64'd0, PIN_NONE, 0, 0);
		setreg(CFG_MIN_SIZE, 64'd0);
		setreg(CFG_MAX_SIZE, 64'd4);
		setreg(CFG_CUT_MASK, ALL_ONES);
		setreg(CFG_SPARE, 64'h0123_4567_89AB_CDEF);
		feed(KIND_DATA, 8'hFF, 8'h00, 64'd0, PIN_FREE, 0, 0);
		feed(KIND_DATA, 8'h00, 8'h00, 64'd0, PIN_FREE, 0, 0);
		feed(KIND_DATA, 8'h00, 8'h00, 64'd0, PIN_FREE, 0, 0);
		feed(KIND_DATA, 8'h00, 8'h00, 64'd0, PIN_ONE, 4, 0);
		// zero hash right after a forced cut: position 0 never cuts, position 1 does
		feed(KIND_DATA, 8'h00, 8'h00, 64'd0, PIN_FREE, 0, 0);
		feed(KIND_EOS, 8'h00, 8'h00, 64'd0, PIN_ONE, 1, 1);
		feed(KIND_SPARE, 8'hFF, 8'hFF, ALL_ONES, PIN_NONE, 0, 0);
		feed(KIND_EOS, 8'h00, 8'h00, 64'd0, PIN_NONE, 0, 0);
		setreg(CFG_MIN_SIZE, 64'd65535);
		setreg(CFG_MAX_SIZE, 64'd65536);
		repeat (5) feed(KIND_DATA, 8'hFF, 8'h00, 64'd0, PIN_NONE, 0, 0);
		// max lowered below the open chunk
		setreg(CFG_MAX_SIZE, 64'd2);
		feed(KIND_DATA, 8'h00, 8'h00, 64'd0, PIN_ONE, 5, 0);
		feed(KIND_DATA, 8'h00, 8'h00, 64'd0, PIN_NONE, 0, 0);
		feed(KIND_DATA, 8'h00, 8'h00, 64'd0, PIN_ONE, 2, 0);
		setreg(CFG_MAX_SIZE, 64'd0);
		feed(KIND_DATA, 8'h00, 8'h00, 64'd0, PIN_ONE, 1, 0);
		setreg(CFG_MIN_SIZE, 64'd0);
		setreg(CFG_MAX_SIZE, 64'd65536);
		setreg(CFG_CUT_MASK, 64'd0);
		feed(KIND_DATA, 8'hFF, 8'h00, 64'd0, PIN_FREE, 0, 0);
		feed(KIND_EOS, 8'h00, 8'h00, 64'd0, PIN_ONE, 1, 1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		streaming = 1'b0;
		foreach (plan[i]) begin
			row = plan[i];
			if (row.op == ROW_REG) begin
				if (streaming) quiesce();
				streaming = 1'b0;
				write_reg(row.sel, row.val);
			end else begin
				if (!streaming) cfg_valid <= 1'b0;
				streaming = 1'b1;
				send_item(row.item, row.pin, row.want);
			end
		end

		// fill the whole gear table before random data hashes anything
		fed = 0;
		for (int i = 0; i < TBL_DEPTH; i++) begin
			it = '0;
			it.kind = KIND_TABLE;
			it.table_index = 8'(i);
			it.table_value = {$urandom, $urandom};
			send_item(it, PIN_FREE, '0);
			fed++;
		end

		phase = 0;
		while (fed < ITEM_TARGET) begin
			quiesce();
			mn = MIN_W'($urandom_range(0, 48));
			mx = LEN_W'(32'(mn) + $urandom_range(1, 200));
			mk = '0;
			repeat ($urandom_range(0, 7)) mk[6'($urandom_range(0, 63))] = 1'b1;
			case ($urandom_range(0, 9))
				0: mn = '0;
				1: mx = '0;
				2: mx = 17'd1;
				3: begin
					mx = '1;
					mk = '0;
					repeat (8) mk[6'($urandom_range(0, 63))] = 1'b1;
				end
				4: mk = ALL_ONES;
				5: mk = '0;
				6: begin
					mn = '0;
					mk = '0;
				end
				default: ;
			endcase
			// every data byte past position 0 cuts here, so a stalled receiver backs up into the input
			if (phase == 1) begin
				mn = '0;
				mx = 17'd65536;
				mk = '0;
			end
			write_reg(CFG_MIN_SIZE, 64'(mn));
			write_reg(CFG_MAX_SIZE, 64'(mx));
			write_reg(CFG_CUT_MASK, mk);
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_SPARE, {$urandom, $urandom});
			cfg_valid <= 1'b0;
			if (phase == 1)
				hold_req = 1'b1;
			n = (phase == 1) ? 300 : $urandom_range(40, 200);
			repeat (n) begin
				it = random_item();
				send_item(it, PIN_FREE, '0);
				if (it.kind != KIND_SPARE)
					fed++;
			end
			phase++;
		end

		quiesce();

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin : sink
		int unsigned seg_left, mode, hold_left, tick;
		seg_left = 0;
		mode = 0;
		hold_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode = $urandom_range(0, 3);
					seg_left = $urandom_range(10, 150);
				end
				seg_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 5) != 0);
					default: out_ready <= (tick % 4 == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : scoreboard
		gcb_out_t res, due;
		bit       made;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_cut(in_item, made, res);
				if (pin_mode == PIN_FREE) begin
					if (made) chunks_due = {chunks_due, res};
				end else if (pin_mode == PIN_ONE) begin
					chunks_due = {chunks_due, pin_want};
				end
			end
			if (out_valid && out_ready) begin
				if (chunks_due.size() == 0) begin
					$display("%0t: unexpected chunk: expected none, got length %0d final %0b",
						$time, out_item.chunk_length, out_item.is_final);
					mismatches++;
				end else begin
					due = chunks_due.pop_front();
					if (out_item.chunk_length !== due.chunk_length) begin
						$display("%0t: chunk_length expected %0d, got %0d",
							$time, due.chunk_length, out_item.chunk_length);
						mismatches++;
					end
					if (out_item.is_final !== due.is_final) begin
						$display("%0t: is_final expected %0b, got %0b",
							$time, due.is_final, out_item.is_final);
						mismatches++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet == STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

endmodule
